FILE: rtl/core/ilir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ilir_pkg: shared types and defaults for the indexed list block
// holds the command and result words, action codes and the per-cell control struct
// no dependencies

package ilir_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int WORD_WIDTH_DEFAULT = 32;

  localparam int ACTION_W = 3;
  localparam int INDEX_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ       = 3'd0,
    ACT_WRITE      = 3'd1,
    ACT_PUSH_BACK  = 3'd2,
    ACT_PUSH_FRONT = 3'd3,
    ACT_INSERT     = 3'd4,
    ACT_POP_BACK   = 3'd5,
    ACT_POP_FRONT  = 3'd6,
    ACT_REMOVE     = 3'd7
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] write_value;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic               ok;
    logic [COUNT_W-1:0] count;
  } result_t;

  // what a cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_FROM_LEFT  = 2'd2,
    CELL_FROM_RIGHT = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/indexed_list_insert_remove.sv
`timescale 1ns / 1ps
`default_nettype none
// indexed_list_insert_remove: bounded ordered list built as a row of entry cells
// depends on ilir_pkg and ilir_cell
//
// usage:
//   a command word (action, index, write_value) is taken at a rising edge with
//   start high and busy low. busy stays low, so a command may be issued every
//   cycle. one result word (read_value, ok, count) appears the next cycle on
//   result, flagged by done for exactly one cycle; the receiver cannot stall.
//   throughput is one command per cycle: every cell loads, holds or takes its
//   left or right neighbor in the same edge, so an insert or a removal shifts
//   the whole tail at once.
//   reads pick the addressed cell through a DEPTH-way select.
//   index at or above count fails with ok low; push or insert into a full list
//   fails; pop on an empty list succeeds and changes nothing.
//   reset (synchronous, rst high) clears the count and the done strobe; the
//   entry cells are not cleared, since only entries below the count are read.

module indexed_list_insert_remove #(
  parameter int DEPTH      = ilir_pkg::DEPTH_DEFAULT,
  parameter int WORD_WIDTH = ilir_pkg::WORD_WIDTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire ilir_pkg::cmd_t    cmd,
  output logic                   done,
  output ilir_pkg::result_t      result
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW = (CW > ilir_pkg::INDEX_W) ? CW : ilir_pkg::INDEX_W;

  logic [CW-1:0]         entry_count;
  logic [CW-1:0]         count_next;
  logic [CMPW-1:0]       idx_x;
  logic [CMPW-1:0]       cnt_x;
  logic                  in_range;
  logic                  has_room;
  logic                  ok_next;
  logic [WORD_WIDTH-1:0] wr_word;
  logic [WORD_WIDTH-1:0] entry_q [DEPTH];
  logic [AW-1:0]         rd_sel;
  logic [ilir_pkg::VALUE_W-1:0] rd_next;

  // never held off
  assign busy = 1'b0;

  assign idx_x    = CMPW'(cmd.index);
  assign cnt_x    = CMPW'(entry_count);
  assign in_range = idx_x < cnt_x;
  assign has_room = entry_count < CW'(DEPTH);
  assign wr_word  = WORD_WIDTH'(cmd.write_value);
  assign rd_sel   = idx_x[AW-1:0];

  always_comb begin
    count_next = entry_count;
    ok_next    = 1'b0;
    rd_next    = '0;
    unique case (cmd.action)
      ilir_pkg::ACT_READ: begin
        if (in_range) begin
          rd_next = ilir_pkg::VALUE_W'(entry_q[rd_sel]);
          ok_next = 1'b1;
        end
      end
      ilir_pkg::ACT_WRITE: begin
        ok_next = in_range;
      end
      ilir_pkg::ACT_PUSH_BACK, ilir_pkg::ACT_PUSH_FRONT: begin
        if (has_room) begin
          count_next = entry_count + CW'(1);
          ok_next    = 1'b1;
        end
      end
      ilir_pkg::ACT_INSERT: begin
        if (in_range && has_room) begin
          count_next = entry_count + CW'(1);
          ok_next    = 1'b1;
        end
      end
      ilir_pkg::ACT_POP_BACK, ilir_pkg::ACT_POP_FRONT: begin
        if (entry_count != '0) begin
          count_next = entry_count - CW'(1);
        end
        ok_next = 1'b1;
      end
      ilir_pkg::ACT_REMOVE: begin
        if (in_range) begin
          count_next = entry_count - CW'(1);
          ok_next    = 1'b1;
        end
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMPW-1:0] POS = CMPW'(i);
    ilir_pkg::cell_ctrl_t  ctrl;
    logic [WORD_WIDTH-1:0] left_data;
    logic [WORD_WIDTH-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = wr_word;
    end else begin : g_left
      assign left_data = entry_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_data = entry_q[i];
    end else begin : g_right
      assign right_data = entry_q[i+1];
    end

    always_comb begin
      ctrl.op = ilir_pkg::CELL_HOLD;
      if (start) begin
        unique case (cmd.action)
          ilir_pkg::ACT_WRITE: begin
            if (in_range && idx_x == POS) ctrl.op = ilir_pkg::CELL_LOAD;
          end
          ilir_pkg::ACT_PUSH_BACK: begin
            if (has_room && cnt_x == POS) ctrl.op = ilir_pkg::CELL_LOAD;
          end
          ilir_pkg::ACT_PUSH_FRONT: begin
            if (has_room) begin
              ctrl.op = (i == 0) ? ilir_pkg::CELL_LOAD : ilir_pkg::CELL_FROM_LEFT;
            end
          end
          ilir_pkg::ACT_INSERT: begin
            if (in_range && has_room) begin
              if (idx_x == POS) begin
                ctrl.op = ilir_pkg::CELL_LOAD;
              end else if (POS > idx_x) begin
                ctrl.op = ilir_pkg::CELL_FROM_LEFT;
              end
            end
          end
          ilir_pkg::ACT_POP_FRONT: begin
            // cells at or above the count hold stale words that are never read
            if (entry_count != '0) ctrl.op = ilir_pkg::CELL_FROM_RIGHT;
          end
          ilir_pkg::ACT_REMOVE: begin
            if (in_range && POS >= idx_x) ctrl.op = ilir_pkg::CELL_FROM_RIGHT;
          end
          default: begin
            ctrl.op = ilir_pkg::CELL_HOLD;
          end
        endcase
      end
    end

    ilir_cell #(
      .WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_data (wr_word),
      .left_data (left_data),
      .right_data(right_data),
      .data      (entry_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        entry_count <= count_next;
      end
    end
  end

  // result word, qualified by done
  always_ff @(posedge clk) begin
    if (start) begin
      result.read_value <= rd_next;
      result.ok         <= ok_next;
      result.count      <= ilir_pkg::COUNT_W'(count_next);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ilir_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ilir_cell: one list entry register with its neighbor shift muxes
// depends on ilir_pkg for the cell control struct

module ilir_cell #(
  parameter int WIDTH = ilir_pkg::WORD_WIDTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire ilir_pkg::cell_ctrl_t ctrl,
  input  wire logic [WIDTH-1:0] load_data,
  input  wire logic [WIDTH-1:0] left_data,
  input  wire logic [WIDTH-1:0] right_data,
  output logic      [WIDTH-1:0] data
);

  logic [WIDTH-1:0] data_next;

  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      ilir_pkg::CELL_HOLD:       data_next = data;
      ilir_pkg::CELL_LOAD:       data_next = load_data;
      ilir_pkg::CELL_FROM_LEFT:  data_next = left_data;
      ilir_pkg::CELL_FROM_RIGHT: data_next = right_data;
      default:                   data_next = data;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

`default_nettype wire
